// ===== rtl/core/bps_pkg.sv =====
`default_nettype none

package bps_pkg;

    localparam int PLANE_W   = 8;
    localparam int COLOUR_W  = 12;
    localparam int INDEX_W   = 3;
    localparam int MODE_W    = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 3;
    localparam int PIX_CNT_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_EIGHT      = 2'd0,
        MODE_MONO       = 2'd1,
        MODE_SIXTY_FOUR = 2'd2,
        MODE_RESERVED   = 2'd3
    } colour_mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COLOUR_MODE     = 2'd0,
        REG_MONO_FOREGROUND = 2'd1,
        REG_MONO_BACKGROUND = 2'd2,
        REG_UNUSED          = 2'd3
    } cfg_reg_t;

    // Settings handed from the register bank to the colour mapper.
    typedef struct packed {
        colour_mode_t       mode;
        logic [INDEX_W-1:0] foreground;
        logic [INDEX_W-1:0] background;
    } map_ctrl_t;

    localparam logic [COLOUR_W-1:0] RED_FULL   = 12'hF00;
    localparam logic [COLOUR_W-1:0] GREEN_FULL = 12'h0F0;
    localparam logic [COLOUR_W-1:0] BLUE_FULL  = 12'h00F;

    // Palette index bit 0 is red, bit 1 green, bit 2 blue.
    function automatic logic [COLOUR_W-1:0] eight_colour(input logic [INDEX_W-1:0] idx);
        logic [COLOUR_W-1:0] c;
        c = '0;
        if (idx[0]) c = c | RED_FULL;
        if (idx[1]) c = c | GREEN_FULL;
        if (idx[2]) c = c | BLUE_FULL;
        return c;
    endfunction

    // A two-bit level becomes a nibble of 0, 5, A or F.
    function automatic logic [3:0] level_nibble(input logic [1:0] lvl);
        return {lvl, lvl};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bps_if.sv =====
`default_nettype none

interface bps_plane_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_plane_byte;
    logic [7:0] green_plane_byte;
    logic [7:0] blue_plane_byte;

    modport source (output valid, output red_plane_byte, output green_plane_byte,
                    output blue_plane_byte, input ready);
    modport sink (input valid, input red_plane_byte, input green_plane_byte,
                  input blue_plane_byte, output ready);
endinterface

interface bps_pixel_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_colour;
    logic        last_pixel;

    modport source (output valid, output pixel_colour, output last_pixel, input ready);
    modport sink (input valid, input pixel_colour, input last_pixel, output ready);
endinterface

interface bps_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [2:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bitplane_pixel_serializer.sv =====
`default_nettype none

// Bit-plane to pixel serialiser. Each item on the plane channel carries one byte from
// each of the red, green and blue planes; the block sends its pixels, leftmost first,
// as RGB444 colours, one per clock unless the output stalls, and flags the last pixel of
// each item. An item gives 8 pixels in eight-colour and mono modes, 4 in sixty-four colour
// mode. The next item is taken in the cycle its predecessor's last pixel is loaded, so
// pixels flow without gaps. Registers are written through the configuration channel,
// which is always ready; the user must write them only while no item is in flight; the
// block does not enforce this. Mode 3 means eight-colour mode; index 3 writes are ignored.
module bitplane_pixel_serializer (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bps_plane_if.sink    planes,
    bps_pixel_if.source  pixels,
    bps_cfg_if.sink      cfg
);
    import bps_pkg::*;

    map_ctrl_t                ctrl_reg;
    logic [PLANE_W-1:0]       red_reg, green_reg, blue_reg;
    logic [PLANE_W-1:0]       red_next, green_next, blue_next;
    logic [PIX_CNT_W-1:0]     count_reg, count_next;
    logic                     busy_reg, busy_next;
    logic                     out_valid_reg, out_valid_next;
    logic [COLOUR_W-1:0]      colour_reg, colour_next;
    logic                     last_reg, last_next;

    logic                     advance;
    logic                     final_pix;
    logic                     take;
    logic                     wide_mode;
    logic [COLOUR_W-1:0]      map_colour;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.mode       <= MODE_EIGHT;
            ctrl_reg.foreground <= INDEX_W'(3);
            ctrl_reg.background <= INDEX_W'(4);
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_COLOUR_MODE:     ctrl_reg.mode       <= colour_mode_t'(cfg.data[MODE_W-1:0]);
                REG_MONO_FOREGROUND: ctrl_reg.foreground <= cfg.data[INDEX_W-1:0];
                REG_MONO_BACKGROUND: ctrl_reg.background <= cfg.data[INDEX_W-1:0];
                default:             ;
            endcase
        end
    end

    bps_pixel_map u_map (
        .ctrl       (ctrl_reg),
        .red_bits   (red_reg[PLANE_W-1 -: 2]),
        .green_bits (green_reg[PLANE_W-1 -: 2]),
        .blue_bits  (blue_reg[PLANE_W-1 -: 2]),
        .colour     (map_colour)
    );

    assign wide_mode = (ctrl_reg.mode == MODE_SIXTY_FOUR);
    assign advance   = busy_reg && (!out_valid_reg || pixels.ready);
    assign final_pix = wide_mode ? (count_reg == PIX_CNT_W'(3)) : (count_reg == PIX_CNT_W'(7));
    assign planes.ready = !busy_reg || (advance && final_pix);
    assign take      = planes.valid && planes.ready;

    always_comb
    begin
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        count_next     = count_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !pixels.ready;
        colour_next    = colour_reg;
        last_next      = last_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            colour_next    = map_colour;
            last_next      = final_pix;
            count_next     = count_reg + PIX_CNT_W'(1);
            if (wide_mode)
            begin
                red_next   = {red_reg[PLANE_W-3:0], 2'b00};
                green_next = {green_reg[PLANE_W-3:0], 2'b00};
                blue_next  = {blue_reg[PLANE_W-3:0], 2'b00};
            end
            else
            begin
                red_next   = {red_reg[PLANE_W-2:0], 1'b0};
                green_next = {green_reg[PLANE_W-2:0], 1'b0};
                blue_next  = {blue_reg[PLANE_W-2:0], 1'b0};
            end
            if (final_pix)
            begin
                busy_next = 1'b0;
            end
        end

        if (take)
        begin
            red_next   = planes.red_plane_byte;
            green_next = planes.green_plane_byte;
            blue_next  = planes.blue_plane_byte;
            count_next = '0;
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        colour_reg <= colour_next;
        last_reg   <= last_next;
    end

    assign pixels.valid        = out_valid_reg;
    assign pixels.pixel_colour = colour_reg;
    assign pixels.last_pixel   = last_reg;

    // An accepted item always leaves the block holding work with the counter at its start.
    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (busy_reg && count_reg == '0))
        else $error("accepted item did not start a fresh pixel run");

    // In sixty-four colour mode an item never runs past its fourth pixel.
    a_wide_count: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && wide_mode) |-> !count_reg[PIX_CNT_W-1])
        else $error("pixel counter overran in sixty-four colour mode");

    // A new pixel only appears when an item was being worked on.
    a_pixel_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg))
        else $error("pixel produced with no item in hand");

    // When an item's final pixel is advanced, the next cycle shows it valid and flagged last.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && final_pix) |=> (last_reg && out_valid_reg))
        else $error("final pixel not flagged as last");

endmodule

`default_nettype wire

// ===== rtl/core/bps_pixel_map.sv =====
`default_nettype none

module bps_pixel_map (
    input  bps_pkg::map_ctrl_t        ctrl,
    input  logic [1:0]                red_bits,
    input  logic [1:0]                green_bits,
    input  logic [1:0]                blue_bits,
    output logic [bps_pkg::COLOUR_W-1:0] colour
);
    import bps_pkg::*;

    logic [INDEX_W-1:0] idx;

    // The leading pixel sits in bit 1 of each pair; the sixty-four colour mode uses both bits.
    always_comb
    begin
        idx = {blue_bits[1], green_bits[1], red_bits[1]};
        case (ctrl.mode)
            MODE_SIXTY_FOUR:
            begin
                colour = {level_nibble(red_bits), level_nibble(green_bits),
                          level_nibble(blue_bits)};
            end
            MODE_MONO:
            begin
                colour = eight_colour(red_bits[1] ? ctrl.foreground : ctrl.background);
            end
            default:
            begin
                colour = eight_colour(idx);
            end
        endcase
    end

endmodule

`default_nettype wire
